>>> hw/rtl/csu_pkg.sv
// Shared types, constants and helper functions for the chi-square uniformity unit.
`default_nettype none
package csu_pkg;

  localparam int BYTE_W    = 8;
  localparam int SW_W      = 6;
  localparam int CNT_W     = 21;
  localparam int MAX_SYM_W = 32;
  localparam int MAX_BINS  = 32;
  localparam int BIN_W     = $clog2(MAX_BINS);
  localparam int K_W       = 3;
  localparam int FRAC_W    = 16;
  localparam int OUT_W     = 41;
  localparam int SQ_W      = 2 * CNT_W;
  localparam int DVD_W     = OUT_W + 5 + FRAC_W;
  localparam int DIV_CNT_W = $clog2(DVD_W);
  localparam int IDX_W     = BIN_W + 1;

  localparam logic [SW_W-1:0]  SYMBOL_BITS_RST  = SW_W'(8);
  localparam logic [CNT_W-1:0] SYMBOL_COUNT_RST = CNT_W'(1024);
  localparam logic [CNT_W-1:0] RUN_LIMIT        = CNT_W'(1048576);

  localparam logic [1:0] REG_SYMBOL_BITS  = 2'd0;
  localparam logic [1:0] REG_SYMBOL_COUNT = 2'd1;

  typedef enum logic [2:0] {
    ST_BIT,
    ST_DRAIN,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [SW_W-1:0] eff_width(input logic [SW_W-1:0] sw);
    logic [SW_W-1:0] w;
    w = sw;
    if (w == '0) w = SW_W'(1);
    if (w > SW_W'(MAX_SYM_W)) w = SW_W'(MAX_SYM_W);
    return w;
  endfunction

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] sc);
    logic [CNT_W-1:0] n;
    n = sc;
    if (n == '0) n = CNT_W'(1);
    if (n > RUN_LIMIT) n = RUN_LIMIT;
    return n;
  endfunction

  function automatic logic [K_W-1:0] log2_ceil(input logic [SW_W-1:0] w);
    logic [SW_W-1:0] wm1;
    logic [K_W-1:0]  k;
    wm1 = w - SW_W'(1);
    k = '0;
    for (int i = 0; i < SW_W; i++) begin
      if (wm1[i]) k = K_W'(i + 1);
    end
    return k;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/csu_front.sv
// Front end: accepts stream bytes into a two-entry request queue.
`default_nettype none
module csu_front (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  [csu_pkg::BYTE_W-1:0]  in_data_byte,
  output logic                        q_valid,
  output logic [csu_pkg::BYTE_W-1:0]  q_data,
  input  wire                         q_pop
);
  import csu_pkg::*;

  logic [BYTE_W-1:0] slot_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        fill_r;
  logic              push;

  assign in_ready = (fill_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill_r != 2'd0);
  assign q_data   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      fill_r <= fill_r + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= in_data_byte;
  end

endmodule
`default_nettype wire

>>> hw/rtl/csu_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module csu_div (
  input  wire                clk,
  input  wire                rst_n,
  input  csu_pkg::div_req_t  req,
  output csu_pkg::div_rsp_t  rsp
);
  import csu_pkg::*;

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     dsr_r;
  logic [DVD_W-1:0]     quo_r;
  logic                 done_r;
  logic [CNT_W:0]       trial;
  logic                 ge;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign ge    = (trial >= {1'b0, dsr_r});

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dsr_r <= req.divisor;
      quo_r <= req.dividend;
    end else if (busy_r) begin
      rem_r <= ge ? CNT_W'(trial - {1'b0, dsr_r}) : CNT_W'(trial);
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/csu_back.sv
// Back end: bit slicer, histogram read-modify-write, sum of squares and statistic.
`default_nettype none
module csu_back (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire  [csu_pkg::SW_W-1:0]    symbol_bits,
  input  wire  [csu_pkg::CNT_W-1:0]   symbol_count,
  input  wire                         q_valid,
  input  wire  [csu_pkg::BYTE_W-1:0]  q_data,
  output logic                        q_pop,
  output logic                        res_valid,
  input  wire                         res_ready,
  output logic [csu_pkg::OUT_W-1:0]   res_chi,
  output logic [csu_pkg::OUT_W-1:0]   res_ss
);
  import csu_pkg::*;

  back_state_t state_r, state_nxt;

  logic [BYTE_W-1:0]    byte_r;
  logic [2:0]           bit_cnt_r;
  logic                 have_r;
  logic [MAX_SYM_W-1:0] partial_r;
  logic [SW_W-1:0]      pbits_r;
  logic [CNT_W-1:0]     done_r;

  logic [CNT_W-1:0]     mem [MAX_BINS];
  logic [CNT_W-1:0]     rdata_r;
  logic [MAX_BINS-1:0]  valid_r;

  logic                 upd_v_r;
  logic [BIN_W-1:0]     upd_bin_r;
  logic                 last_v_r;
  logic [BIN_W-1:0]     last_bin_r;
  logic [CNT_W-1:0]     last_val_r;

  logic [IDX_W-1:0]     sum_idx_r;
  logic                 s1_v_r, s2_v_r;
  logic [BIN_W-1:0]     s1_idx_r;
  logic [OUT_W-1:0]     sq_r;
  logic [OUT_W-1:0]     acc_r;

  div_req_t dreq;
  div_rsp_t drsp;

  logic [SW_W-1:0]      w;
  logic [K_W-1:0]       k;
  logic [CNT_W-1:0]     run_len;
  logic                 work;
  logic [BYTE_W-1:0]    cur_byte;
  logic [2:0]           cur_cnt;
  logic [MAX_SYM_W-1:0] new_sym;
  logic [MAX_SYM_W-1:0] sym_mask;
  logic [MAX_SYM_W-1:0] sym;
  logic [SW_W-1:0]      pbits_inc;
  logic                 complete;
  logic [BIN_W-1:0]     bin_new;
  logic [CNT_W-1:0]     done_inc;
  logic                 close;
  logic [CNT_W-1:0]     upd_base;
  logic [CNT_W-1:0]     s1_val;
  logic                 sum_issue;
  logic                 sum_end;
  logic [DVD_W-1:0]     sub_val;
  logic [BIN_W-1:0]     rd_addr;

  assign w        = eff_width(symbol_bits);
  assign k        = log2_ceil(w);
  assign run_len  = eff_count(symbol_count);
  assign cur_byte = have_r ? byte_r : q_data;
  assign cur_cnt  = have_r ? bit_cnt_r : 3'd0;
  assign work     = (state_r == ST_BIT) && (have_r || q_valid);
  assign new_sym  = {partial_r[MAX_SYM_W-2:0], cur_byte[BYTE_W-1]};
  assign sym_mask = {MAX_SYM_W{1'b1}} >> (SW_W'(MAX_SYM_W) - w);
  assign sym      = new_sym & sym_mask;
  assign pbits_inc = pbits_r + SW_W'(1);
  assign complete = work && (pbits_inc >= w);
  assign bin_new  = BIN_W'(sym >> (w - SW_W'(k)));
  assign done_inc = done_r + CNT_W'(1);
  assign close    = complete && (done_inc >= run_len);
  assign upd_base = (last_v_r && last_bin_r == upd_bin_r) ? last_val_r :
                    (valid_r[upd_bin_r] ? rdata_r : '0);
  assign s1_val   = valid_r[s1_idx_r] ? rdata_r : '0;
  assign sum_issue = (state_r == ST_SUM) && (sum_idx_r < IDX_W'(MAX_BINS));
  assign sum_end  = (state_r == ST_SUM) && !sum_issue && !s1_v_r && !s2_v_r;
  assign rd_addr  = (state_r == ST_SUM) ? sum_idx_r[BIN_W-1:0] : bin_new;
  assign sub_val  = DVD_W'({done_r, {FRAC_W{1'b0}}});

  assign dreq.start    = sum_end;
  assign dreq.dividend = DVD_W'({acc_r, {FRAC_W{1'b0}}}) << k;
  assign dreq.divisor  = done_r;

  csu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_BIT:   if (close) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_SUM;
      ST_SUM:   if (sum_end) state_nxt = ST_DIV;
      ST_DIV:   if (drsp.done) state_nxt = ST_EMIT;
      ST_EMIT:  if (res_ready) state_nxt = ST_BIT;
      default:  state_nxt = ST_BIT;
    endcase
  end

  always_comb begin
    q_pop     = (state_r == ST_BIT) && !have_r && q_valid;
    res_valid = (state_r == ST_EMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_BIT;
      have_r    <= 1'b0;
      bit_cnt_r <= '0;
      pbits_r   <= '0;
      done_r    <= '0;
      partial_r <= '0;
      valid_r   <= '0;
      upd_v_r   <= 1'b0;
      last_v_r  <= 1'b0;
      sum_idx_r <= '0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      upd_v_r  <= complete;
      last_v_r <= upd_v_r;
      s1_v_r   <= sum_issue;
      s2_v_r   <= s1_v_r;
      if (work) begin
        have_r    <= (cur_cnt != 3'd7) && !close;
        bit_cnt_r <= cur_cnt + 3'd1;
        if (complete) begin
          partial_r <= '0;
          pbits_r   <= '0;
          done_r    <= done_inc;
        end else begin
          partial_r <= new_sym;
          pbits_r   <= pbits_inc;
        end
      end
      if (upd_v_r) valid_r[upd_bin_r] <= 1'b1;
      if (state_r == ST_DRAIN) sum_idx_r <= '0;
      else if (sum_issue) sum_idx_r <= sum_idx_r + IDX_W'(1);
      if ((state_r == ST_EMIT) && res_ready) begin
        valid_r <= '0;
        done_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (work) byte_r <= cur_byte << 1;
    upd_bin_r  <= bin_new;
    last_bin_r <= upd_bin_r;
    last_val_r <= upd_base + CNT_W'(1);
    rdata_r    <= mem[rd_addr];
    if (upd_v_r) mem[upd_bin_r] <= upd_base + CNT_W'(1);
    s1_idx_r <= sum_idx_r[BIN_W-1:0];
    sq_r     <= OUT_W'(SQ_W'(s1_val) * SQ_W'(s1_val));
    if (state_r == ST_DRAIN) acc_r <= '0;
    else if (s2_v_r) acc_r <= acc_r + sq_r;
    if (drsp.done) begin
      res_ss  <= acc_r;
      res_chi <= (drsp.quotient > sub_val) ? OUT_W'(drsp.quotient - sub_val) : '0;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/bitstream_chi_square_uniformity_unit.sv
// Top level: config registers, request queue, back end and output register.
// Throughput: one bit per cycle while a run is in progress and a byte is on hand.
// The bit that closes a run stalls the byte stream through the drain state, the sum of
// squares over the 32 bins, the bit-serial divider and the hand-off to the output register.
// Synchronous active-low reset clears the histogram valid bits and counters, restores config.
`default_nettype none
module bitstream_chi_square_uniformity_unit (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire  [1:0]                  cfg_index,
  input  wire  [csu_pkg::CNT_W-1:0]   cfg_data,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  [csu_pkg::BYTE_W-1:0]  in_data_byte,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [csu_pkg::OUT_W-1:0]   out_chi_fixed,
  output logic [csu_pkg::OUT_W-1:0]   out_sum_squares
);
  import csu_pkg::*;

  logic [SW_W-1:0]   symbol_bits_r;
  logic [CNT_W-1:0]  symbol_count_r;
  logic              q_valid, q_pop;
  logic [BYTE_W-1:0] q_data;
  logic              res_valid, res_ready;
  logic [OUT_W-1:0]  res_chi, res_ss;
  logic              out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      symbol_bits_r  <= SYMBOL_BITS_RST;
      symbol_count_r <= SYMBOL_COUNT_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_SYMBOL_BITS) symbol_bits_r <= cfg_data[SW_W-1:0];
      if (cfg_index == REG_SYMBOL_COUNT) symbol_count_r <= cfg_data;
    end
  end

  csu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop)
  );

  csu_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .symbol_bits  (symbol_bits_r),
    .symbol_count (symbol_count_r),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_chi      (res_chi),
    .res_ss       (res_ss)
  );

  assign res_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_chi_fixed   <= res_chi;
      out_sum_squares <= res_ss;
    end
  end

endmodule
`default_nettype wire
